### rtl/core/assert_macros.svh
// assertion macros shared by the rtl core
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/core/ps2s1_pkg.sv
// types, key codes and the character rom for the set 1 scan code decoder
// no dependencies
`timescale 1ns / 1ps

package ps2s1_pkg;

    localparam int ByteW = 8;
    localparam int KeyW  = 7;
    localparam int CharW = 7;
    localparam int RomIdxW = 6;

    localparam logic [ByteW-1:0] PREFIX_BYTE = 8'hE0;
    localparam logic [KeyW-1:0]  LAST_KEY    = 7'h3A;
    localparam logic [KeyW-1:0]  K_LCTRL     = 7'h1D;
    localparam logic [KeyW-1:0]  K_LSHIFT    = 7'h2A;
    localparam logic [KeyW-1:0]  K_RSHIFT    = 7'h36;
    localparam logic [KeyW-1:0]  K_LALT      = 7'h38;
    localparam logic [KeyW-1:0]  K_CAPS      = 7'h3A;

    typedef struct packed {
        logic shift;
        logic ctrl;
        logic alt;
        logic caps;
    } mods_t;

    // keys whose column follows shift only
    function automatic logic caps_ignored(input logic [KeyW-1:0] key);
        logic hit;
        begin
            hit = (key < 7'h0E) || (key == 7'h1A) || (key == 7'h1B) || (key == 7'h27)
                || (key == 7'h28) || (key == 7'h29) || (key == 7'h2B) || (key == 7'h33)
                || (key == 7'h34) || (key == 7'h35);
            return hit;
        end
    endfunction

    // two-column rom: {shifted, plain}
    function automatic logic [2*CharW-1:0] rom_pair(input logic [RomIdxW-1:0] idx);
        logic [2*CharW-1:0] pair;
        begin
            case (idx)
                6'h01: pair = {7'h1B, 7'h1B};
                6'h02: pair = {7'h21, 7'h31};
                6'h03: pair = {7'h40, 7'h32};
                6'h04: pair = {7'h23, 7'h33};
                6'h05: pair = {7'h24, 7'h34};
                6'h06: pair = {7'h25, 7'h35};
                6'h07: pair = {7'h5E, 7'h36};
                6'h08: pair = {7'h26, 7'h37};
                6'h09: pair = {7'h2A, 7'h38};
                6'h0A: pair = {7'h28, 7'h39};
                6'h0B: pair = {7'h29, 7'h30};
                6'h0C: pair = {7'h5F, 7'h2D};
                6'h0D: pair = {7'h2B, 7'h3D};
                6'h0E: pair = {7'h08, 7'h08};
                6'h0F: pair = {7'h09, 7'h09};
                6'h10: pair = {7'h51, 7'h71};
                6'h11: pair = {7'h57, 7'h77};
                6'h12: pair = {7'h45, 7'h65};
                6'h13: pair = {7'h52, 7'h72};
                6'h14: pair = {7'h54, 7'h74};
                6'h15: pair = {7'h59, 7'h79};
                6'h16: pair = {7'h55, 7'h75};
                6'h17: pair = {7'h49, 7'h69};
                6'h18: pair = {7'h4F, 7'h6F};
                6'h19: pair = {7'h50, 7'h70};
                6'h1A: pair = {7'h7B, 7'h5B};
                6'h1B: pair = {7'h7D, 7'h5D};
                6'h1C: pair = {7'h0A, 7'h0A};
                6'h1E: pair = {7'h41, 7'h61};
                6'h1F: pair = {7'h53, 7'h73};
                6'h20: pair = {7'h44, 7'h64};
                6'h21: pair = {7'h46, 7'h66};
                6'h22: pair = {7'h47, 7'h67};
                6'h23: pair = {7'h48, 7'h68};
                6'h24: pair = {7'h4A, 7'h6A};
                6'h25: pair = {7'h4B, 7'h6B};
                6'h26: pair = {7'h4C, 7'h6C};
                6'h27: pair = {7'h3A, 7'h3B};
                6'h28: pair = {7'h22, 7'h27};
                6'h29: pair = {7'h7E, 7'h60};
                6'h2B: pair = {7'h7C, 7'h5C};
                6'h2C: pair = {7'h5A, 7'h7A};
                6'h2D: pair = {7'h58, 7'h78};
                6'h2E: pair = {7'h43, 7'h63};
                6'h2F: pair = {7'h56, 7'h76};
                6'h30: pair = {7'h42, 7'h62};
                6'h31: pair = {7'h4E, 7'h6E};
                6'h32: pair = {7'h4D, 7'h6D};
                6'h33: pair = {7'h3C, 7'h2C};
                6'h34: pair = {7'h3E, 7'h2E};
                6'h35: pair = {7'h3F, 7'h2F};
                6'h37: pair = {7'h2A, 7'h2A};
                6'h39: pair = {7'h20, 7'h20};
                default: pair = '0;
            endcase
            return pair;
        end
    endfunction

endpackage

### rtl/core/ps2_set1_scancode_to_ascii.sv
// set 1 scan code to ascii decoder, top level
// depends on ps2s1_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  in      | input     | in_valid, in_stall | scan_byte
//  out     | output    | out_valid,out_stall| char_valid, char_code, unknown_key,
//          |           |                    | shift_held, ctrl_held, alt_held, caps_on
//
//  one transaction per cycle sustained while out_stall is low; an accepted byte passes the input
//  register, then the result register, with the decode between them
//  the modifier and prefix flags update as a byte moves into the result register
//  async active-low reset clears both pipeline valids, the prefix flag and all modifiers
//  out_stall holds the result register; in_stall rises only when both registers are full

module ps2_set1_scancode_to_ascii
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [ps2s1_pkg::ByteW-1:0] scan_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        char_valid,
    output logic [ps2s1_pkg::CharW-1:0] char_code,
    output logic                        unknown_key,
    output logic                        shift_held,
    output logic                        ctrl_held,
    output logic                        alt_held,
    output logic                        caps_on
);

    import ps2s1_pkg::*;

    // input stage
    logic             in_full_reg;
    logic             in_full_next;
    logic [ByteW-1:0] byte_reg;

    // decoder state
    logic  prefix_reg;
    logic  prefix_next;
    mods_t mods_reg;
    mods_t mods_next;

    // result stage
    logic             out_full_reg;
    logic             out_full_next;
    logic             char_valid_reg;
    logic             char_valid_next;
    logic [CharW-1:0] char_code_reg;
    logic [CharW-1:0] char_code_next;
    logic             unknown_reg;
    logic             unknown_next;

    logic             advance;
    logic             in_take;
    logic [KeyW-1:0]  key;
    logic             known_make;
    logic             column;
    logic [2*CharW-1:0] pair;
    logic [CharW-1:0] rom_char;

    // the byte in the input register moves on when the result register is free or draining
    assign advance  = in_full_reg && (!out_full_reg || !out_stall);
    assign in_stall = in_full_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    assign key = byte_reg[KeyW-1:0];

    // extended makes only know right ctrl and right alt
    assign known_make = prefix_reg ? ((key == K_LCTRL) || (key == K_LALT))
                                   : ((key != '0) && (key <= LAST_KEY));

    // letters and other keys outside the shift-only set follow shift xor caps, the rest follow shift alone
    assign column   = caps_ignored(key) ? mods_reg.shift : (mods_reg.shift ^ mods_reg.caps);
    assign pair     = rom_pair(key[RomIdxW-1:0]);
    assign rom_char = column ? pair[2*CharW-1:CharW] : pair[CharW-1:0];

    always_comb
    begin
        prefix_next     = prefix_reg;
        mods_next       = mods_reg;
        char_valid_next = 1'b0;
        char_code_next  = '0;
        unknown_next    = 1'b0;
        if (byte_reg == PREFIX_BYTE)
        begin
            prefix_next = 1'b1;
        end
        else
        begin
            prefix_next = 1'b0;
            if (byte_reg[ByteW-1])
            begin
                // break: release the matching modifier; extended shift breaks are ignored
                unique case (key) inside
                    K_LCTRL:
                    begin
                        mods_next.ctrl = 1'b0;
                    end
                    K_LSHIFT, K_RSHIFT:
                    begin
                        if (!prefix_reg)
                        begin
                            mods_next.shift = 1'b0;
                        end
                    end
                    K_LALT:
                    begin
                        mods_next.alt = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (known_make)
            begin
                if (rom_char != '0)
                begin
                    char_valid_next = 1'b1;
                    char_code_next  = rom_char;
                end
                else
                begin
                    // empty rom entry: modifier or caps lock key
                    unique case (key) inside
                        K_LCTRL:
                        begin
                            mods_next.ctrl = 1'b1;
                        end
                        K_LSHIFT, K_RSHIFT:
                        begin
                            mods_next.shift = 1'b1;
                        end
                        K_LALT:
                        begin
                            mods_next.alt = 1'b1;
                        end
                        K_CAPS:
                        begin
                            mods_next.caps = !mods_reg.caps;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            else
            begin
                unknown_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        in_full_next = in_full_reg;
        if (in_take)
        begin
            in_full_next = 1'b1;
        end
        else if (advance)
        begin
            in_full_next = 1'b0;
        end
    end

    always_comb
    begin
        out_full_next = out_full_reg;
        if (advance)
        begin
            out_full_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_full_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg  <= 1'b0;
            out_full_reg <= 1'b0;
            prefix_reg   <= 1'b0;
            mods_reg     <= '0;
        end
        else
        begin
            in_full_reg  <= in_full_next;
            out_full_reg <= out_full_next;
            if (advance)
            begin
                prefix_reg <= prefix_next;
                mods_reg   <= mods_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg <= scan_byte;
        end
        if (advance)
        begin
            char_valid_reg <= char_valid_next;
            char_code_reg  <= char_code_next;
            unknown_reg    <= unknown_next;
        end
    end

    // modifier outputs show the flags after the byte held in the result register
    assign out_valid   = out_full_reg;
    assign char_valid  = char_valid_reg;
    assign char_code   = char_code_reg;
    assign unknown_key = unknown_reg;
    assign shift_held  = mods_reg.shift;
    assign ctrl_held   = mods_reg.ctrl;
    assign alt_held    = mods_reg.alt;
    assign caps_on     = mods_reg.caps;

    `ASSERT_IMPLY(a_char_not_unknown, clk, rst_n, out_valid && char_valid, !unknown_key, "character flagged as unknown key")
    `ASSERT_IMPLY(a_code_zero_idle, clk, rst_n, out_valid && !char_valid, char_code == '0, "char_code nonzero without char_valid")
    `ASSERT_NEXT(a_flags_hold, clk, rst_n, !advance, $stable(mods_reg) && $stable(prefix_reg), "decoder state changed without a transaction")
    `ASSERT_NEXT(a_prefix_armed, clk, rst_n, advance && (byte_reg == PREFIX_BYTE), prefix_reg && !char_valid && !unknown_key, "prefix byte not handled")

endmodule

### test/tb_ps2_set1_scancode_to_ascii.sv
// self-checking testbench for the set 1 scan code to ascii decoder
// depends on ps2s1_pkg and ps2_set1_scancode_to_ascii; checks every result against
// a built-in decoder of its own with randomized idle and stall on both channels
`timescale 1ns / 1ps

module tb_ps2_set1_scancode_to_ascii;

    import ps2s1_pkg::*;

    // no accepted transaction on either channel for this many cycles means a hang
    localparam int WATCHDOG_LIMIT = 2000;
    // the decoder has two pipeline registers, so a short tail covers any late result
    localparam int TAIL_CYCLES = 8;
    // length of one long receiver hold-off
    localparam int HOLD_OFF_CYCLES = 60;

    // character columns indexed by make code 0x00..0x3A, entry 0 at the left end
    localparam logic [8*59-1:0] PLAIN_COL = {
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
        8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B,
        8'h6C, 8'h3B, 8'h27, 8'h60, 8'h00, 8'h5C,
        8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D, 8'h2C,
        8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00
    };
    localparam logic [8*59-1:0] SHIFTED_COL = {
        8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
        8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
        8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B,
        8'h4C, 8'h3A, 8'h22, 8'h7E, 8'h00, 8'h7C,
        8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D, 8'h3C,
        8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00
    };

    // keys whose column follows shift alone: digit row and punctuation
    localparam logic [58:0] SHIFT_ONLY_KEYS = 59'h3FFF
        | (59'd1 << 8'h1A) | (59'd1 << 8'h1B) | (59'd1 << 8'h27) | (59'd1 << 8'h28)
        | (59'd1 << 8'h29) | (59'd1 << 8'h2B) | (59'd1 << 8'h33) | (59'd1 << 8'h34)
        | (59'd1 << 8'h35);

    typedef struct packed {
        logic               char_valid;
        logic [CharW-1:0]   char_code;
        logic               unknown_key;
        logic               shift_held;
        logic               ctrl_held;
        logic               alt_held;
        logic               caps_on;
    } key_report_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [ByteW-1:0]   scan_byte = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               char_valid;
    logic [CharW-1:0]   char_code;
    logic               unknown_key;
    logic               shift_held;
    logic               ctrl_held;
    logic               alt_held;
    logic               caps_on;

    // decoder state as the testbench sees it
    logic prefix_armed = 1'b0;
    logic shift_down = 1'b0;
    logic ctrl_down = 1'b0;
    logic alt_down = 1'b0;
    logic caps_latched = 1'b0;

    key_report_t key_reports_due[$];

    int in_idle_pct = 0;
    int out_stall_pct = 0;
    // hold-off requests from the tests, counted down by the receiver alone
    int hold_off_req = 0;
    int hold_off_seen = 0;
    int hold_off_left = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    ps2_set1_scancode_to_ascii uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .scan_byte   (scan_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .char_valid  (char_valid),
        .char_code   (char_code),
        .unknown_key (unknown_key),
        .shift_held  (shift_held),
        .ctrl_held   (ctrl_held),
        .alt_held    (alt_held),
        .caps_on     (caps_on)
    );

    // 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // decode one accepted byte and advance the prefix and modifier flags
    function automatic key_report_t decode_scan_byte(input logic [ByteW-1:0] b);
        key_report_t rep;
        logic        ext;
        logic [6:0]  key;
        logic        upper;
        logic [7:0]  ch;
        rep = '0;
        if (b == PREFIX_BYTE)
        begin
            // a repeated prefix simply stays armed
            prefix_armed = 1'b1;
        end
        else
        begin
            ext = prefix_armed;
            prefix_armed = 1'b0;
            key = b[6:0];
            if (b[7])
            begin
                // break code: only ctrl, alt and non-extended shift releases matter
                if (key == K_LCTRL)
                    ctrl_down = 1'b0;
                else if (!ext && (key == K_LSHIFT || key == K_RSHIFT))
                    shift_down = 1'b0;
                else if (key == K_LALT)
                    alt_down = 1'b0;
            end
            else if (ext ? (key == K_LCTRL || key == K_LALT)
                         : (key != 7'd0 && key <= LAST_KEY))
            begin
                // extended keys are never in the shift-only set
                upper = (!ext && SHIFT_ONLY_KEYS[key]) ? shift_down
                                                       : (shift_down ^ caps_latched);
                ch = upper ? SHIFTED_COL[(58 - key) * 8 +: 8]
                           : PLAIN_COL[(58 - key) * 8 +: 8];
                if (ch != 8'd0)
                begin
                    rep.char_valid = 1'b1;
                    rep.char_code = ch[6:0];
                end
                else if (key == K_LCTRL)
                    ctrl_down = 1'b1;
                else if (key == K_LSHIFT || key == K_RSHIFT)
                    shift_down = 1'b1;
                else if (key == K_LALT)
                    alt_down = 1'b1;
                else if (key == K_CAPS)
                    caps_latched = !caps_latched;
            end
            else
            begin
                rep.unknown_key = 1'b1;
            end
        end
        rep.shift_held = shift_down;
        rep.ctrl_held = ctrl_down;
        rep.alt_held = alt_down;
        rep.caps_on = caps_latched;
        return rep;
    endfunction

    // offer one byte from a falling edge and hold it until the transaction completes
    task automatic send_byte(input logic [ByteW-1:0] b);
        @(negedge clk);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        scan_byte = b;
        do
            @(posedge clk);
        while (in_stall);
        key_reports_due.push_back(decode_scan_byte(b));
    endtask

    // sender stops and waits for every outstanding result
    task automatic wait_all_reported();
        @(negedge clk);
        in_valid = 1'b0;
        while (key_reports_due.size() != 0)
            @(posedge clk);
    endtask

    // mostly realistic keystrokes with random content, plus raw noise bytes
    task automatic type_random(input int count);
        int         sent;
        int         pick;
        logic [6:0] key;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99);
            key = 7'($urandom_range(1, 58));
            if (pick < 40)
            begin
                // plain make of any key in the table
                send_byte({1'b0, key});
                sent++;
            end
            else if (pick < 55)
            begin
                // release of any key
                send_byte({1'b1, key});
                sent++;
            end
            else if (pick < 70)
            begin
                // modifier press or release
                case ($urandom_range(3))
                    0: key = K_LSHIFT;
                    1: key = K_RSHIFT;
                    2: key = K_LCTRL;
                    default: key = K_LALT;
                endcase
                send_byte({1'($urandom_range(1)), key});
                sent++;
            end
            else if (pick < 75)
            begin
                send_byte({1'b0, K_CAPS});
                sent++;
            end
            else if (pick < 88)
            begin
                // extended sequence: right ctrl/alt, fake shifts, or anything
                case ($urandom_range(4))
                    0: key = K_LCTRL;
                    1: key = K_LALT;
                    2: key = K_LSHIFT;
                    3: key = K_RSHIFT;
                    default: key = 7'($urandom_range(127));
                endcase
                send_byte(PREFIX_BYTE);
                send_byte({1'($urandom_range(1)), key});
                sent += 2;
            end
            else
            begin
                // noise: any byte at all
                send_byte(8'($urandom_range(255)));
                sent++;
            end
        end
    endtask

    // extremes of the byte, each kind of code and the documented corner cases
    task automatic test_directed_codes();
        in_idle_pct = 0;
        out_stall_pct = 0;
        send_byte(8'h00);                 // make code zero is unknown
        send_byte(8'hFF);                 // top byte, a break of nothing
        send_byte(8'h7F);                 // highest make, unknown
        send_byte(8'h01);                 // escape
        send_byte(8'h1E);                 // lower-case a
        send_byte({1'b0, K_CAPS});        // caps lock on
        send_byte(8'h1E);                 // caps gives upper-case
        send_byte(8'h02);                 // digit ignores caps
        send_byte({1'b0, K_RSHIFT});      // right shift down
        send_byte(8'h1E);                 // shift cancels caps on a letter
        send_byte(8'h02);                 // shifted digit
        send_byte(PREFIX_BYTE);
        send_byte({1'b1, K_RSHIFT});      // extended shift break leaves shift held
        send_byte({1'b1, K_LSHIFT});      // left shift break clears shift
        send_byte({1'b0, K_CAPS});        // caps lock off
        send_byte(PREFIX_BYTE);
        send_byte(PREFIX_BYTE);           // prefix twice stays armed
        send_byte({1'b0, K_LCTRL});       // right ctrl make
        send_byte(PREFIX_BYTE);
        send_byte({1'b1, K_LCTRL});       // right ctrl break
        send_byte(PREFIX_BYTE);
        send_byte({1'b0, K_LALT});        // right alt make
        send_byte({1'b1, K_LALT});        // left alt break releases it too
        send_byte(PREFIX_BYTE);
        send_byte(8'h1C);                 // any other extended make is unknown
        wait_all_reported();
    endtask

    task automatic test_typing_slow_receiver();
        in_idle_pct = 9;
        out_stall_pct = 66;
        type_random(400);
        wait_all_reported();
    endtask

    task automatic test_typing_slow_sender();
        in_idle_pct = 66;
        out_stall_pct = 9;
        type_random(400);
        wait_all_reported();
    endtask

    task automatic test_typing_full_rate();
        in_idle_pct = 0;
        out_stall_pct = 0;
        type_random(400);
        wait_all_reported();
    endtask

    // receiver holds off long enough that both registers fill and input stalls
    task automatic test_output_hold_off();
        in_idle_pct = 0;
        out_stall_pct = 0;
        hold_off_req++;
        type_random(30);
        wait_all_reported();
    endtask

    // receiver: long hold-off when asked, random stall otherwise
    always @(negedge clk)
    begin
        if (hold_off_req != hold_off_seen)
        begin
            hold_off_seen = hold_off_req;
            hold_off_left = HOLD_OFF_CYCLES;
        end
        if (hold_off_left > 0)
        begin
            out_stall = 1'b1;
            hold_off_left--;
        end
        else
        begin
            out_stall = ($urandom_range(99) < out_stall_pct);
        end
    end

    // result check on every accepted output transaction
    always @(posedge clk)
    begin
        key_report_t got;
        key_report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{char_valid, char_code, unknown_key, shift_held, ctrl_held,
                    alt_held, caps_on};
            if (key_reports_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h at %0t", got, $realtime);
            end
            else
            begin
                want = key_reports_due.pop_front();
                if (got.char_valid !== want.char_valid || got.char_code !== want.char_code
                    || got.unknown_key !== want.unknown_key
                    || got.shift_held !== want.shift_held
                    || got.ctrl_held !== want.ctrl_held || got.alt_held !== want.alt_held
                    || got.caps_on !== want.caps_on)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch at %0t: valid/char/unk/sh/ct/al/cp", $realtime);
                        $display("  exp %b %h %b %b %b %b %b",
                                 want.char_valid, want.char_code, want.unknown_key,
                                 want.shift_held, want.ctrl_held, want.alt_held,
                                 want.caps_on);
                        $display("  got %b %h %b %b %b %b %b",
                                 got.char_valid, got.char_code, got.unknown_key,
                                 got.shift_held, got.ctrl_held, got.alt_held,
                                 got.caps_on);
                    end
                end
            end
        end
    end

    // watchdog: too long without any accepted transaction ends the run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_codes();
        test_typing_slow_receiver();
        test_typing_slow_sender();
        test_typing_full_rate();
        test_output_hold_off();

        // nothing outstanding; a short tail catches any stray result
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && key_reports_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/ps2s1_pkg.sv
rtl/core/ps2_set1_scancode_to_ascii.sv
test/tb_ps2_set1_scancode_to_ascii.sv
